@@ design/jsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the JSON string unescaper.
// No dependencies.

package jsu_pkg;

    localparam int CapW   = 16;
    localparam int ByteW  = 8;
    localparam int MaxRes = 3;

    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_HEX3 = 3'd4,
        PH_HEX4 = 3'd5
    } jsu_phase_t;

    localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
    localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
    localparam logic [ByteW-1:0] CH_N      = 8'h6E;
    localparam logic [ByteW-1:0] CH_R      = 8'h72;
    localparam logic [ByteW-1:0] CH_B      = 8'h62;
    localparam logic [ByteW-1:0] CH_T      = 8'h74;
    localparam logic [ByteW-1:0] CH_F      = 8'h66;
    localparam logic [ByteW-1:0] CH_U      = 8'h75;

    localparam logic [ByteW-1:0] CC_LF = 8'h0A;
    localparam logic [ByteW-1:0] CC_CR = 8'h0D;
    localparam logic [ByteW-1:0] CC_BS = 8'h08;
    localparam logic [ByteW-1:0] CC_HT = 8'h09;
    localparam logic [ByteW-1:0] CC_FF = 8'h0C;

    // room a u escape needs before its digits are read
    localparam logic [CapW-1:0] U_ROOM = 16'd4;

    typedef struct packed {
        jsu_phase_t      phase;
        logic [15:0]     hex;
        logic            stopped;
        logic [CapW-1:0] written;
        logic            halted;
    } jsu_state_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             has_byte;
        logic             last;
    } jsu_res_t;

    // {valid, value} of one hex character
    function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

@@ design/json_string_unescape.sv @@
`timescale 1ns / 1ps
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg and jsu_decode.

// Raw string-body bytes enter on s_axis one item per clock while it is ready;
// each is decoded in the cycle it is accepted and its results (none to three)
// land in a three-entry result buffer that drains on m_axis one item per clock
// while m_axis_tready is high. Plain text and simple escapes stream at one
// byte per cycle while the output is ready; a \u escape that expands to more
// than one UTF-8 byte holds the input while the buffer drains. An s_axis_tlast
// item closes the string: it yields one result with tlast set and tuser clear,
// and restarts decoding. cfg_wdata sets the per-string output capacity (reset
// 65535) and must be written only while the block is idle (not enforced).

module json_string_unescape
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [jsu_pkg::CapW-1:0]      cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [jsu_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tlast,   // end_of_string
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [jsu_pkg::ByteW-1:0]     m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tuser,   // has_byte
    output logic                          m_axis_tlast    // last
);

    logic [jsu_pkg::CapW-1:0]                cap_reg;
    jsu_pkg::jsu_state_t                     st_reg;
    jsu_pkg::jsu_state_t                     st_next;
    jsu_pkg::jsu_res_t [jsu_pkg::MaxRes-1:0] buf_reg;
    jsu_pkg::jsu_res_t [jsu_pkg::MaxRes-1:0] dec_res;
    logic [1:0]                              dec_cnt;
    logic [1:0]                              rem_reg;
    logic                                    accept;
    logic                                    pop;

    jsu_decode u_decode
    (
        .st            (st_reg),
        .in_byte       (s_axis_tdata),
        .end_of_string (s_axis_tlast),
        .capacity      (cap_reg),
        .st_next       (st_next),
        .res           (dec_res),
        .res_cnt       (dec_cnt)
    );

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (rem_reg != 2'd0);
    assign m_axis_tdata  = buf_reg[0].data;
    assign m_axis_tuser  = buf_reg[0].has_byte;
    assign m_axis_tlast  = buf_reg[0].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= '1;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            rem_reg <= 2'd0;
        end
        else if (accept)
        begin
            st_reg  <= st_next;
            rem_reg <= dec_cnt;
        end
        else if (pop)
            rem_reg <= rem_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_reg <= dec_res;
        else if (pop)
            buf_reg <= {buf_reg[jsu_pkg::MaxRes-1], buf_reg[jsu_pkg::MaxRes-1:1]};
    end

endmodule

@@ design/jsu_decode.sv @@
`timescale 1ns / 1ps
// Combinational step of the unescaper: one item plus current state gives the
// next state and up to three result entries. Depends on jsu_pkg.

module jsu_decode
(
    input  jsu_pkg::jsu_state_t                  st,
    input  logic [jsu_pkg::ByteW-1:0]            in_byte,
    input  logic                                 end_of_string,
    input  logic [jsu_pkg::CapW-1:0]             capacity,
    output jsu_pkg::jsu_state_t                  st_next,
    output jsu_pkg::jsu_res_t [jsu_pkg::MaxRes-1:0] res,
    output logic [1:0]                           res_cnt
);

    logic [4:0]                 dig;
    logic [15:0]                cp;
    logic [jsu_pkg::CapW:0]     room;
    logic                       short_room;

    assign dig        = jsu_pkg::hex_digit(in_byte);
    assign room       = {1'b0, capacity} - {1'b0, st.written};
    assign short_room = room[jsu_pkg::CapW] || (room[jsu_pkg::CapW-1:0] < jsu_pkg::U_ROOM);
    assign cp         = (!st.stopped && dig[4]) ? {st.hex[11:0], dig[3:0]} : st.hex;

    always_comb
    begin
        st_next = st;
        res     = '0;
        res_cnt = 2'd0;

        if (end_of_string)
        begin
            st_next     = '0;
            res[0].last = 1'b1;
            res_cnt     = 2'd1;
        end
        else if (!st.halted)
        begin
            unique case (st.phase)
                jsu_pkg::PH_TEXT:
                begin
                    if (st.written >= capacity)
                        st_next.halted = 1'b1;
                    else if (in_byte == jsu_pkg::CH_BSLASH)
                        st_next.phase = jsu_pkg::PH_ESC;
                    else
                    begin
                        res[0]  = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
                        res_cnt = 2'd1;
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    st_next.phase = jsu_pkg::PH_TEXT;
                    res_cnt       = 2'd1;
                    res[0].has_byte = 1'b1;
                    unique case (in_byte)
                        jsu_pkg::CH_N:      res[0].data = jsu_pkg::CC_LF;
                        jsu_pkg::CH_R:      res[0].data = jsu_pkg::CC_CR;
                        jsu_pkg::CH_B:      res[0].data = jsu_pkg::CC_BS;
                        jsu_pkg::CH_T:      res[0].data = jsu_pkg::CC_HT;
                        jsu_pkg::CH_F:      res[0].data = jsu_pkg::CC_FF;
                        jsu_pkg::CH_BSLASH,
                        jsu_pkg::CH_SLASH,
                        jsu_pkg::CH_QUOTE:  res[0].data = in_byte;
                        jsu_pkg::CH_U:
                        begin
                            res[0].has_byte = 1'b0;
                            res_cnt         = 2'd0;
                            if (short_room)
                                st_next.halted = 1'b1;
                            else
                            begin
                                st_next.phase   = jsu_pkg::PH_HEX1;
                                st_next.hex     = '0;
                                st_next.stopped = 1'b0;
                            end
                        end
                        default:
                        begin
                            res[0].has_byte = 1'b0;
                            res_cnt         = 2'd0;
                        end
                    endcase
                end
                jsu_pkg::PH_HEX1,
                jsu_pkg::PH_HEX2,
                jsu_pkg::PH_HEX3:
                begin
                    st_next.hex     = cp;
                    st_next.stopped = st.stopped || !dig[4];
                    st_next.phase   = jsu_pkg::jsu_phase_t'(st.phase + 3'd1);
                end
                jsu_pkg::PH_HEX4:
                begin
                    st_next.phase   = jsu_pkg::PH_TEXT;
                    st_next.hex     = '0;
                    st_next.stopped = 1'b0;
                    if (cp <= 16'h007F)
                    begin
                        res[0]  = '{data: cp[7:0], has_byte: 1'b1, last: 1'b0};
                        res_cnt = 2'd1;
                    end
                    else if (cp <= 16'h07FF)
                    begin
                        res[0]  = '{data: {3'b110, cp[10:6]}, has_byte: 1'b1, last: 1'b0};
                        res[1]  = '{data: {2'b10, cp[5:0]}, has_byte: 1'b1, last: 1'b0};
                        res_cnt = 2'd2;
                    end
                    else
                    begin
                        res[0]  = '{data: {4'b1110, cp[15:12]}, has_byte: 1'b1, last: 1'b0};
                        res[1]  = '{data: {2'b10, cp[11:6]}, has_byte: 1'b1, last: 1'b0};
                        res[2]  = '{data: {2'b10, cp[5:0]}, has_byte: 1'b1, last: 1'b0};
                        res_cnt = 2'd3;
                    end
                end
                default:
                    st_next.phase = jsu_pkg::PH_TEXT;
            endcase
            st_next.written = st.written + jsu_pkg::CapW'(res_cnt);
        end
    end

endmodule

@@ design/jsu_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for json_string_unescape, bound to the top level.
// Depends on json_string_unescape.

module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // every item is either a byte or the string close
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
        else $error("result item is neither a byte nor a close");

    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == 8'h00))
        else $error("close item carries data");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result buffer");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescape: directed and random string bodies,
// several output capacities and handshake idling modes, checked against an in-bench decoder.
// Depends on jsu_pkg and the json_string_unescape RTL.

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 300;
    localparam logic [jsu_pkg::ByteW-1:0] SHORT_ESCAPES [8] = '{
        jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_B, jsu_pkg::CH_T, jsu_pkg::CH_F,
        jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [jsu_pkg::CapW-1:0]  cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [jsu_pkg::ByteW-1:0] s_axis_tdata = '0;    // [7:0] in_byte
    logic                      s_axis_tlast = 1'b0;  // end_of_string
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [jsu_pkg::ByteW-1:0] m_axis_tdata;         // [7:0] out_byte
    logic                      m_axis_tuser;         // has_byte
    logic                      m_axis_tlast;         // last

    // decoder state mirrored by the bench
    jsu_pkg::jsu_phase_t       str_phase;
    logic [15:0]               str_hex;
    logic                      str_stopped;
    logic [jsu_pkg::CapW-1:0]  str_written;
    logic                      str_halted;
    logic [jsu_pkg::CapW-1:0]  out_capacity;

    jsu_pkg::jsu_res_t         decoded_q[$];
    jsu_pkg::jsu_res_t         want_res;
    int                        error_count = 0;
    int                        items_sent = 0;
    int                        quiet_cycles = 0;
    int                        sender_idle_pct = 0;
    int                        sink_stall_pct = 0;

    json_string_unescape dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- decoder ----------------

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic clear_string();
        str_phase = jsu_pkg::PH_TEXT;
        str_hex = '0;
        str_stopped = 1'b0;
        str_written = '0;
        str_halted = 1'b0;
    endtask

    task automatic push_result(input logic [7:0] b, input logic has, input logic fin);
        jsu_pkg::jsu_res_t r;
        r.data = b;
        r.has_byte = has;
        r.last = fin;
        decoded_q.push_back(r);
    endtask

    task automatic expect_byte(input logic [7:0] b);
        push_result(b, 1'b1, 1'b0);
        str_written = str_written + 16'd1;
    endtask

    task automatic expect_utf8(input logic [15:0] cp);
        if (cp <= 16'h007F)
            expect_byte(cp[7:0]);
        else if (cp <= 16'h07FF)
        begin
            expect_byte({3'b110, cp[10:6]});
            expect_byte({2'b10, cp[5:0]});
        end
        else
        begin
            expect_byte({4'b1110, cp[15:12]});
            expect_byte({2'b10, cp[11:6]});
            expect_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic decode_item(input logic [7:0] c, input logic eos);
        int          d;
        logic [15:0] cp;
        d = nibble_of(c);
        if (eos)
        begin
            push_result(8'h00, 1'b0, 1'b1);
            clear_string();
        end
        else if (!str_halted)
        begin
            case (str_phase)
                jsu_pkg::PH_TEXT:
                    if (str_written >= out_capacity)
                        str_halted = 1'b1;
                    else if (c == jsu_pkg::CH_BSLASH)
                        str_phase = jsu_pkg::PH_ESC;
                    else
                        expect_byte(c);
                jsu_pkg::PH_ESC:
                begin
                    str_phase = jsu_pkg::PH_TEXT;
                    case (c)
                        jsu_pkg::CH_N: expect_byte(jsu_pkg::CC_LF);
                        jsu_pkg::CH_R: expect_byte(jsu_pkg::CC_CR);
                        jsu_pkg::CH_B: expect_byte(jsu_pkg::CC_BS);
                        jsu_pkg::CH_T: expect_byte(jsu_pkg::CC_HT);
                        jsu_pkg::CH_F: expect_byte(jsu_pkg::CC_FF);
                        jsu_pkg::CH_BSLASH,
                        jsu_pkg::CH_SLASH,
                        jsu_pkg::CH_QUOTE: expect_byte(c);
                        jsu_pkg::CH_U:
                            if (out_capacity < str_written
                                || out_capacity - str_written < jsu_pkg::U_ROOM)
                                str_halted = 1'b1;
                            else
                            begin
                                str_phase = jsu_pkg::PH_HEX1;
                                str_hex = '0;
                                str_stopped = 1'b0;
                            end
                        default: ;
                    endcase
                end
                default:
                begin
                    if (!str_stopped && d >= 0)
                        str_hex = {str_hex[11:0], 4'(d)};
                    else
                        str_stopped = 1'b1;
                    if (str_phase != jsu_pkg::PH_HEX4)
                        str_phase = jsu_pkg::jsu_phase_t'(str_phase + 3'd1);
                    else
                    begin
                        cp = str_hex;
                        str_phase = jsu_pkg::PH_TEXT;
                        str_hex = '0;
                        str_stopped = 1'b0;
                        expect_utf8(cp);
                    end
                end
            endcase
        end
    endtask

    // ---------------- monitor, checker, sink, watchdog ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_capacity = 16'hFFFF;
            clear_string();
        end
        else
        begin
            if (cfg_we)
                out_capacity = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                decode_item(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h has_byte %b last %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want_res = decoded_q.pop_front();
                    if (m_axis_tdata !== want_res.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want_res.data, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== want_res.has_byte)
                    begin
                        $error("has_byte: expected %b, got %b", want_res.has_byte, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== want_res.last)
                    begin
                        $error("last: expected %b, got %b", want_res.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(3, 1);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [jsu_pkg::CapW-1:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    task automatic send_u_escape(input int digits);
        logic [15:0] cp;
        int          band;
        band = $urandom_range(2);
        if (band == 0)
            cp = 16'($urandom_range(16'h007F));
        else if (band == 1)
            cp = 16'($urandom_range(16'h07FF, 16'h0080));
        else
            cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        send_item(jsu_pkg::CH_BSLASH, 1'b0);
        send_item(jsu_pkg::CH_U, 1'b0);
        for (int j = 0; j < digits; j++)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0);
            else
                send_item(hex_char(cp[15 - 4 * j -: 4]), 1'b0);
        end
    endtask

    task automatic send_random_string();
        int segs;
        int kind;
        segs = $urandom_range(10);
        for (int i = 0; i < segs; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                send_item(8'($urandom_range(255)), 1'b0);
            else if (kind < 65)
            begin
                send_item(jsu_pkg::CH_BSLASH, 1'b0);
                send_item(SHORT_ESCAPES[$urandom_range(7)], 1'b0);
            end
            else if (kind < 70)
            begin
                send_item(jsu_pkg::CH_BSLASH, 1'b0);
                send_item(8'($urandom_range(255)), 1'b0);
            end
            else if (kind < 93)
                send_u_escape(4);
            else
            begin
                // cut off inside an escape
                if ($urandom_range(1))
                    send_item(jsu_pkg::CH_BSLASH, 1'b0);
                else
                    send_u_escape($urandom_range(3));
                break;
            end
        end
        send_end();
    endtask

    // ---------------- tests ----------------

    task automatic test_plain_bytes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_end();
    endtask

    task automatic test_short_escapes();
        send_text("\\n\\\"\\q\\");
        send_end();
    endtask

    task automatic test_unicode_escapes();
        send_text("\\u07FF\\uD83");
        send_end();
    endtask

    task automatic test_capacity_limits();
        set_capacity(16'd0);
        send_text("a");
        send_end();
        set_capacity(16'd2);
        send_text("\\u0041b");
        send_end();
    endtask

    task automatic test_random_strings();
        int target;
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 51;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct = 51;
                end
                default:
                begin
                    sender_idle_pct = 20;
                    sink_stall_pct = 20;
                end
            endcase
            for (int k = 0; k < 3; k++)
            begin
                if (mode == 0 && k == 0)
                    set_capacity(16'hFFFF);
                else if (mode == 3 && k == 2)
                    set_capacity(16'd0);
                else if ($urandom_range(3) < 2)
                    set_capacity(16'($urandom_range(12, 1)));
                else if ($urandom_range(1))
                    set_capacity(16'($urandom_range(16'hFFFF)));
                else
                    set_capacity(16'hFFFF);
                target = items_sent + RANDOM_ITEMS / 12;
                while (items_sent < target)
                    send_random_string();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_short_escapes();
        test_unicode_escapes();
        test_capacity_limits();
        test_random_strings();
        settle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
